/* src/b64_pkg.sv */
`default_nettype none
package b64_pkg;

   localparam int JOB_SLOTS  = 4;
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] CHAR_PAD   = 8'h3D;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       error;
      logic       out_last;
   } rsp_type;

   // up to four results caused by one input item
   typedef struct packed {
      logic [2:0]                  cnt;
      rsp_type [JOB_SLOTS-1:0]     ent;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   function automatic logic [7:0] enc_char(input logic [5:0] six);
      logic [7:0] c;
      if (six < 6'd26)      c = 8'h41 + {2'b00, six};
      else if (six < 6'd52) c = 8'h61 + {2'b00, six} - 8'd26;
      else if (six < 6'd62) c = 8'h30 + {2'b00, six} - 8'd52;
      else if (six == 6'd62) c = 8'h2B;
      else                  c = 8'h2F;
      return c;
   endfunction

   // returns {is_alphabet, sextet}
   function automatic logic [6:0] dec_sextet(input logic [7:0] c);
      logic [6:0] r;
      if (c >= 8'h41 && c <= 8'h5A)      r = {1'b1, 6'(c - 8'h41)};
      else if (c >= 8'h61 && c <= 8'h7A) r = {1'b1, 6'(c - 8'h61 + 8'd26)};
      else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c - 8'h30 + 8'd52)};
      else if (c == 8'h2B)               r = {1'b1, 6'd62};
      else if (c == 8'h2F)               r = {1'b1, 6'd63};
      else                               r = 7'd0;
      return r;
   endfunction

endpackage
`default_nettype wire

/* src/b64_front.sv */
`default_nettype none
module b64_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   input  wire logic             csr_data,
   input  wire logic             take,
   input  wire b64_pkg::req_type req_data,
   output b64_pkg::job_type      job,
   output logic                  push
);
   import b64_pkg::*;

   logic        mode_ff, mode_in;
   logic [15:0] carry_ff, carry_in;
   logic [2:0]  held_ff, held_in;
   logic        disc_ff, disc_in;

   always_comb begin
      logic [23:0] v;
      logic [6:0]  sx;
      logic [3:0]  bits;
      logic [2:0]  sh;
      logic [15:0] cat;
      logic        skip;
      logic [1:0]  li;

      job      = '0;
      li       = 2'd0;
      carry_in = carry_ff;
      held_in  = held_ff;
      disc_in  = disc_ff;
      v        = {carry_ff, req_data.in_byte};
      sx       = dec_sextet(req_data.in_byte);
      bits     = {1'b0, held_ff} + 4'd6;
      sh       = 3'(bits - 4'd8);
      cat      = {carry_ff[9:0], sx[5:0]};
      skip     = req_data.in_byte == CHAR_PAD || req_data.in_byte == CHAR_CR ||
                 req_data.in_byte == CHAR_LF || req_data.in_byte == CHAR_SPACE;

      if (mode_ff == MODE_ENCODE) begin
         if (held_ff >= 3'd2) begin
            job.cnt = 3'd4;
            job.ent[0] = '{enc_char(v[23:18]), 1'b1, 1'b0, 1'b0};
            job.ent[1] = '{enc_char(v[17:12]), 1'b1, 1'b0, 1'b0};
            job.ent[2] = '{enc_char(v[11:6]),  1'b1, 1'b0, 1'b0};
            job.ent[3] = '{enc_char(v[5:0]),   1'b1, 1'b0, 1'b0};
            carry_in = '0;
            held_in  = '0;
         end else begin
            carry_in = {carry_ff[7:0], req_data.in_byte};
            held_in  = held_ff + 3'd1;
         end
         // flush leftover bytes with padding
         if (req_data.in_last && held_in == 3'd1) begin
            job.cnt = 3'd4;
            job.ent[0] = '{enc_char(carry_in[7:2]), 1'b1, 1'b0, 1'b0};
            job.ent[1] = '{enc_char({carry_in[1:0], 4'b0}), 1'b1, 1'b0, 1'b0};
            job.ent[2] = '{CHAR_PAD, 1'b1, 1'b0, 1'b0};
            job.ent[3] = '{CHAR_PAD, 1'b1, 1'b0, 1'b0};
         end else if (req_data.in_last && held_in == 3'd2) begin
            job.cnt = 3'd4;
            job.ent[0] = '{enc_char(carry_in[15:10]), 1'b1, 1'b0, 1'b0};
            job.ent[1] = '{enc_char(carry_in[9:4]), 1'b1, 1'b0, 1'b0};
            job.ent[2] = '{enc_char({carry_in[3:0], 2'b0}), 1'b1, 1'b0, 1'b0};
            job.ent[3] = '{CHAR_PAD, 1'b1, 1'b0, 1'b0};
         end
      end else if (!disc_ff && !skip) begin
         if (!sx[6]) begin
            job.cnt    = 3'd1;
            job.ent[0] = '{8'h00, 1'b0, 1'b1, 1'b0};
            disc_in    = 1'b1;
         end else if (bits >= 4'd8) begin
            job.cnt    = 3'd1;
            job.ent[0] = '{8'(cat >> sh), 1'b1, 1'b0, 1'b0};
            carry_in   = cat & ~(16'hFFFF << sh);
            held_in    = sh;
         end else begin
            carry_in = cat;
            held_in  = bits[2:0];
         end
      end else if (disc_ff && req_data.in_last) begin
         job.cnt    = 3'd1;
         job.ent[0] = '{8'h00, 1'b0, 1'b1, 1'b0};
      end

      if (req_data.in_last) begin
         if (job.cnt == 3'd0) begin
            job.cnt    = 3'd1;
            job.ent[0] = '0;
         end
         li = 2'(job.cnt - 3'd1);
         job.ent[li].out_last = 1'b1;
         carry_in = '0;
         held_in  = '0;
         disc_in  = 1'b0;
      end

      mode_in = mode_ff;
      if (csr_valid) begin
         mode_in  = csr_data;
         carry_in = '0;
         held_in  = '0;
         disc_in  = 1'b0;
      end else if (!take) begin
         carry_in = carry_ff;
         held_in  = held_ff;
         disc_in  = disc_ff;
      end
   end

   assign push = take && job.cnt != 3'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_ENCODE;
         carry_ff <= '0;
         held_ff  <= '0;
         disc_ff  <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         carry_ff <= carry_in;
         held_ff  <= held_in;
         disc_ff  <= disc_in;
      end
   end

endmodule
`default_nettype wire

/* src/b64_fifo.sv */
`default_nettype none
module b64_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire b64_pkg::job_type push_job,
   input  wire logic             pop,
   output b64_pkg::job_type      head,
   output b64_pkg::fifo_stat_type stat
);
   import b64_pkg::*;

   job_type                mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ff, wr_in;
   logic [FIFO_PTR_W-1:0]  rd_ff, rd_in;
   logic [FIFO_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign stat.full  = cnt_ff == FIFO_CNT_W'(FIFO_DEPTH);
   assign stat.empty = cnt_ff == '0;
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? FIFO_PTR_W'((32'(wr_ff) + 1) % FIFO_DEPTH) : wr_ff;
      rd_in  = do_pop  ? FIFO_PTR_W'((32'(rd_ff) + 1) % FIFO_DEPTH) : rd_ff;
      cnt_in = cnt_ff + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

/* src/b64_back.sv */
`default_nettype none
module b64_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire b64_pkg::job_type      head,
   input  wire logic                  q_empty,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output b64_pkg::rsp_type           rsp_data
);
   import b64_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       fin;

   assign rsp_valid = !q_empty;
   assign rsp_data  = head.ent[idx_ff];
   assign fin       = ({1'b0, idx_ff} + 3'd1) == head.cnt;
   assign pop       = rsp_valid && rsp_ready && fin;

   always_comb begin
      idx_in = idx_ff;
      if (rsp_valid && rsp_ready) begin
         idx_in = fin ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule
`default_nettype wire

/* src/base64_stream_codec.sv */
`default_nettype none
// Streaming base64 codec, standard alphabet with '=' padding. Write csr_data (0 encode,
// 1 decode) only while idle; the write also starts a new message. One byte enters per
// transfer on req_; each message ends with an rsp_ result marked out_last. The front
// takes a byte every cycle while its two-entry job queue has room and turns it into a
// job of up to four results; the back sends one result per cycle from the queue head
// while rsp_ready is high, so each result is registered in the job queue before it
// appears. Decode sustains one byte per cycle while rsp_ready is high; encode is
// bounded by the output port at four results per three bytes; a short last group is padded.
module base64_stream_codec (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_data,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire b64_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output b64_pkg::rsp_type      rsp_data
);
   import b64_pkg::*;

   job_type       job, head;
   fifo_stat_type stat;
   logic          push, pop, take;

   assign csr_ready = 1'b1;
   assign req_ready = !stat.full;
   assign take      = req_valid && req_ready;

   b64_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .take      (take),
      .req_data  (req_data),
      .job       (job),
      .push      (push)
   );

   b64_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (job),
      .pop      (pop),
      .head     (head),
      .stat     (stat)
   );

   b64_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_empty   (stat.empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // a result with neither data nor error only closes a message
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_valid && !rsp_data.error |-> rsp_data.out_last)
      else $error("empty result not marked last");

   a_no_data_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_valid |-> rsp_data.out_byte == 8'h00)
      else $error("byte set on a result without data");

   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error |-> !rsp_data.out_valid)
      else $error("error result carries data");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !stat.full)
      else $error("job pushed into a full queue");

endmodule
`default_nettype wire
